>>> hw/rtl/cbt_pkg.sv
package cbt_pkg;

  // Tree size and derived widths
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 2;

  // Request codes
  localparam logic [2:0] FUNC_INSERT   = 3'd0;
  localparam logic [2:0] FUNC_INORDER  = 3'd1;
  localparam logic [2:0] FUNC_PREORDER = 3'd2;
  localparam logic [2:0] FUNC_POSTORD  = 3'd3;
  localparam logic [2:0] FUNC_SEARCH   = 3'd4;

  // Result status codes
  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_ELEMENT   = 3'd2;
  localparam logic [2:0] STAT_EMPTY     = 3'd3;
  localparam logic [2:0] STAT_FOUND     = 3'd4;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd5;

  // Node index moves
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_LEFT,
    IDX_RIGHT,
    IDX_PARENT,
    IDX_INC
  } idx_op_e;

  // Controller to datapath
  typedef struct packed {
    idx_op_e idx_op;
    logic    ram_we;
    logic    load_key;
    logic    scan;
    logic    hold_cap;
    logic    emit_elem;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_left;
    logic has_right;
    logic sib_ok;
    logic is_left;
    logic is_root;
    logic idx_last;
    logic cnt_zero;
    logic full;
    logic found;
  } stat_t;

endpackage

>>> hw/rtl/cbt_ram.sv
module cbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry into a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cbt_dp.sv
module cbt_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cbt_pkg::cmd_t                     cmd_i,
  input  logic signed [cbt_pkg::DATA_W-1:0] value_i,
  output cbt_pkg::stat_t                    stat_o,
  output logic signed [cbt_pkg::DATA_W-1:0] out_value_o
);

  logic [cbt_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [cbt_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        found_q, found_d;
  logic                        cmp_pend_q;
  logic [cbt_pkg::DATA_W-1:0]  key_q;
  logic [cbt_pkg::DATA_W-1:0]  hold_q;
  logic [cbt_pkg::DATA_W-1:0]  out_value_q;
  logic [cbt_pkg::DATA_W-1:0]  rdata;
  logic [cbt_pkg::CHILD_W-1:0] child_l;
  logic [cbt_pkg::CHILD_W-1:0] child_r;
  logic [cbt_pkg::CHILD_W-1:0] count_ext;
  logic [cbt_pkg::CNT_W-1:0]   idx_p1;
  logic [cbt_pkg::IDX_W-1:0]   parent;

  // Node storage, appended at the fill count
  cbt_ram #(
    .WIDTH (cbt_pkg::DATA_W),
    .DEPTH (cbt_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (count_q[cbt_pkg::IDX_W-1:0]),
    .wdata_i ($unsigned(value_i)),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Neighbor indexes of the current node
  assign child_l   = {1'b0, idx_q, 1'b0} + cbt_pkg::CHILD_W'(1);
  assign child_r   = {1'b0, idx_q, 1'b0} + cbt_pkg::CHILD_W'(2);
  assign count_ext = cbt_pkg::CHILD_W'(count_q);
  assign idx_p1    = cbt_pkg::CNT_W'(idx_q) + cbt_pkg::CNT_W'(1);
  assign parent    = (idx_q - cbt_pkg::IDX_W'(1)) >> 1;

  // Move the node index
  always_comb begin
    unique case (cmd_i.idx_op)
      cbt_pkg::IDX_HOLD:   idx_d = idx_q;
      cbt_pkg::IDX_ZERO:   idx_d = '0;
      cbt_pkg::IDX_LEFT:   idx_d = child_l[cbt_pkg::IDX_W-1:0];
      cbt_pkg::IDX_RIGHT:  idx_d = child_r[cbt_pkg::IDX_W-1:0];
      cbt_pkg::IDX_PARENT: idx_d = parent;
      cbt_pkg::IDX_INC:    idx_d = idx_p1[cbt_pkg::IDX_W-1:0];
      default:             idx_d = idx_q;
    endcase
  end

  // Count appends, track search hits
  always_comb begin
    count_d = cmd_i.ram_we ? count_q + cbt_pkg::CNT_W'(1) : count_q;
    if (cmd_i.load_key) begin
      found_d = 1'b0;
    end else if (cmp_pend_q && (rdata == key_q)) begin
      found_d = 1'b1;
    end else begin
      found_d = found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      count_q    <= '0;
      found_q    <= 1'b0;
      cmp_pend_q <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      count_q    <= count_d;
      found_q    <= found_d;
      cmp_pend_q <= cmd_i.scan;
    end
  end

  // Hold the search key, the visited value and the outgoing beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= $unsigned(value_i);
    end
    if (cmd_i.hold_cap) begin
      hold_q <= rdata;
    end
    out_value_q <= cmd_i.emit_elem ? hold_q : '0;
  end

  assign out_value_o = $signed(out_value_q);

  // Status toward the controller
  assign stat_o.has_left  = child_l < count_ext;
  assign stat_o.has_right = child_r < count_ext;
  assign stat_o.sib_ok    = idx_p1 < count_q;
  assign stat_o.is_left   = idx_q[0];
  assign stat_o.is_root   = idx_q == '0;
  assign stat_o.idx_last  = idx_p1 == count_q;
  assign stat_o.cnt_zero  = count_q == '0;
  assign stat_o.full      = count_q == cbt_pkg::CNT_W'(cbt_pkg::CAPACITY);
  assign stat_o.found     = found_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cbt_pkg::CNT_W'(cbt_pkg::CAPACITY))
    else $error("fill count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ram_we |-> (count_q != cbt_pkg::CNT_W'(cbt_pkg::CAPACITY)))
    else $error("append into a full tree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> $past(cmp_pend_q))
    else $error("search hit without a compare");
`endif

endmodule

>>> hw/rtl/cbt_ctrl.sv
module cbt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2:0]     func_i,
  input  cbt_pkg::stat_t stat_i,
  output cbt_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           strobe_o,
  output logic           last_o,
  output logic [2:0]     status_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DESC_L,
    S_DESC_P,
    S_READ,
    S_CAPT,
    S_NEXT_IN,
    S_UP_IN,
    S_NEXT_PRE,
    S_UP_PRE,
    S_NEXT_POST,
    S_FLUSH,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    ORD_IN,
    ORD_PRE,
    ORD_POST
  } order_e;

  state_e     state_q, state_d;
  order_e     ord_q, ord_d;
  logic       pend_q, pend_d;
  logic       strobe_q, strobe_d;
  logic       last_q, last_d;
  logic [2:0] status_q, status_d;

  // Next state, datapath command and the next result beat
  always_comb begin
    state_d  = state_q;
    ord_d    = ord_q;
    pend_d   = pend_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    status_d = status_q;
    cmd_o    = '{idx_op: cbt_pkg::IDX_HOLD, default: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            cbt_pkg::FUNC_INSERT: begin
              strobe_d = 1'b1;
              last_d   = 1'b1;
              if (stat_i.full) begin
                status_d = cbt_pkg::STAT_FULL;
              end else begin
                status_d     = cbt_pkg::STAT_INSERTED;
                cmd_o.ram_we = 1'b1;
              end
            end
            cbt_pkg::FUNC_INORDER, cbt_pkg::FUNC_PREORDER, cbt_pkg::FUNC_POSTORD: begin
              if (stat_i.cnt_zero) begin
                strobe_d = 1'b1;
                last_d   = 1'b1;
                status_d = cbt_pkg::STAT_EMPTY;
              end else begin
                cmd_o.idx_op = cbt_pkg::IDX_ZERO;
                pend_d       = 1'b0;
                if (func_i == cbt_pkg::FUNC_INORDER) begin
                  ord_d   = ORD_IN;
                  state_d = S_DESC_L;
                end else if (func_i == cbt_pkg::FUNC_PREORDER) begin
                  ord_d   = ORD_PRE;
                  state_d = S_READ;
                end else begin
                  ord_d   = ORD_POST;
                  state_d = S_DESC_P;
                end
              end
            end
            cbt_pkg::FUNC_SEARCH: begin
              if (stat_i.cnt_zero) begin
                strobe_d = 1'b1;
                last_d   = 1'b1;
                status_d = cbt_pkg::STAT_NOT_FOUND;
              end else begin
                cmd_o.idx_op   = cbt_pkg::IDX_ZERO;
                cmd_o.load_key = 1'b1;
                state_d        = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      // Walk down to the leftmost node
      S_DESC_L: begin
        if (stat_i.has_left) begin
          cmd_o.idx_op = cbt_pkg::IDX_LEFT;
        end else begin
          state_d = S_READ;
        end
      end

      // Walk down to the first node of a postorder subtree
      S_DESC_P: begin
        if (stat_i.has_left) begin
          cmd_o.idx_op = cbt_pkg::IDX_LEFT;
        end else if (stat_i.has_right) begin
          cmd_o.idx_op = cbt_pkg::IDX_RIGHT;
        end else begin
          state_d = S_READ;
        end
      end

      // Wait for the node value
      S_READ: begin
        state_d = S_CAPT;
      end

      // Capture the node, send the one held before it
      S_CAPT: begin
        cmd_o.hold_cap  = 1'b1;
        cmd_o.emit_elem = pend_q;
        strobe_d        = pend_q;
        status_d        = cbt_pkg::STAT_ELEMENT;
        pend_d          = 1'b1;
        unique case (ord_q)
          ORD_IN:   state_d = S_NEXT_IN;
          ORD_PRE:  state_d = S_NEXT_PRE;
          default:  state_d = S_NEXT_POST;
        endcase
      end

      S_NEXT_IN: begin
        if (stat_i.has_right) begin
          cmd_o.idx_op = cbt_pkg::IDX_RIGHT;
          state_d      = S_DESC_L;
        end else begin
          state_d = S_UP_IN;
        end
      end

      // Climb past right children, then visit the parent
      S_UP_IN: begin
        if (stat_i.is_root) begin
          state_d = S_FLUSH;
        end else if (stat_i.is_left) begin
          cmd_o.idx_op = cbt_pkg::IDX_PARENT;
          state_d      = S_READ;
        end else begin
          cmd_o.idx_op = cbt_pkg::IDX_PARENT;
        end
      end

      S_NEXT_PRE: begin
        if (stat_i.has_left) begin
          cmd_o.idx_op = cbt_pkg::IDX_LEFT;
          state_d      = S_READ;
        end else begin
          state_d = S_UP_PRE;
        end
      end

      // Climb until a right sibling exists
      S_UP_PRE: begin
        if (stat_i.is_root) begin
          state_d = S_FLUSH;
        end else if (stat_i.is_left && stat_i.sib_ok) begin
          cmd_o.idx_op = cbt_pkg::IDX_INC;
          state_d      = S_READ;
        end else begin
          cmd_o.idx_op = cbt_pkg::IDX_PARENT;
        end
      end

      S_NEXT_POST: begin
        if (stat_i.is_root) begin
          state_d = S_FLUSH;
        end else if (stat_i.is_left && stat_i.sib_ok) begin
          cmd_o.idx_op = cbt_pkg::IDX_INC;
          state_d      = S_DESC_P;
        end else begin
          cmd_o.idx_op = cbt_pkg::IDX_PARENT;
          state_d      = S_READ;
        end
      end

      // Send the final held node
      S_FLUSH: begin
        cmd_o.emit_elem = 1'b1;
        strobe_d        = 1'b1;
        last_d          = 1'b1;
        status_d        = cbt_pkg::STAT_ELEMENT;
        state_d         = S_IDLE;
      end

      // Read one entry a cycle, compare it in the cycle after
      S_SCAN: begin
        cmd_o.idx_op = cbt_pkg::IDX_INC;
        cmd_o.scan   = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        state_d = S_RESULT;
      end

      S_RESULT: begin
        strobe_d = 1'b1;
        last_d   = 1'b1;
        status_d = stat_i.found ? cbt_pkg::STAT_FOUND : cbt_pkg::STAT_NOT_FOUND;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ord_q    <= ORD_IN;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      status_q <= cbt_pkg::STAT_INSERTED;
    end else begin
      state_q  <= state_d;
      ord_q    <= ord_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  assign busy_o   = state_q != S_IDLE;
  assign strobe_o = strobe_q;
  assign last_o   = last_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && (status_q != cbt_pkg::STAT_ELEMENT)) |-> last_q)
    else $error("single-beat result without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !last_q) |-> (state_q != S_IDLE))
    else $error("traversal stream ended without last beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> pend_q)
    else $error("flush with no held node");
`endif

endmodule

>>> hw/rtl/complete_binary_tree_traversal_unit.sv
// Complete binary tree kept as an array in level order (children of node i at
// 2i+1 and 2i+2), up to 64 nodes. A request is taken when start is high and
// busy is low. Results come out as one-cycle beats on strobe_o and cannot be
// held off. Insert, and any traversal or search of an empty tree, answer with
// one beat in the cycle after acceptance and leave busy low, so a new request
// can follow at once. A traversal walks the tree one index step per cycle and
// pauses at each node for the storage read; its last beat comes in the same
// cycle that busy falls. A search reads one entry per cycle from the node
// memory and ends with a single result beat. Codes 5 to 7 on func_i are
// dropped without a result.
module complete_binary_tree_traversal_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        func_i,
  input  logic signed [cbt_pkg::DATA_W-1:0] value_i,
  output logic                              strobe_o,
  output logic signed [cbt_pkg::DATA_W-1:0] out_value_o,
  output logic                              last_o,
  output logic [2:0]                        status_o
);

  cbt_pkg::cmd_t  cmd;
  cbt_pkg::stat_t stat;
  logic           busy_int;

  cbt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .func_i   (func_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_int),
    .strobe_o (strobe_o),
    .last_o   (last_o),
    .status_o (status_o)
  );

  cbt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .stat_o      (stat),
    .out_value_o (out_value_o)
  );

  assign busy = busy_int;

endmodule

>>> tb/complete_binary_tree_traversal_unit_tb.sv
module complete_binary_tree_traversal_unit_tb;
  import cbt_pkg::*;

  // Codes the block drops without a result
  localparam logic [2:0] FUNC_RSVD5 = 3'd5;
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  localparam int RANDOM_REQS  = 480;
  localparam int DRAIN_CYCLES = 400;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [2:0]        func;
    logic [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic [2:0]        status;
  } beat_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [2:0]               func_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     strobe_o;
  logic signed [DATA_W-1:0] out_value_o;
  logic                     last_o;
  logic [2:0]               status_o;

  // Request backlog and expected result beats
  request_t pending_reqs[$];
  beat_t    expected_beats[$];

  // Predicted tree contents
  logic [DATA_W-1:0] tree_vals[CAPACITY];
  int unsigned       tree_cnt;
  logic [DATA_W-1:0] visit_buf[CAPACITY];

  // Stimulus-side view of the tree, used to pick search keys and repeated insert values
  logic [DATA_W-1:0] gen_vals[$];

  request_t    cur_req;
  beat_t       exp_beat;
  logic        beat_taken;
  int unsigned total_reqs;
  int unsigned driven_cnt;
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned fail_cnt;
  int unsigned n_insert, n_refused, n_walk, n_search, n_dropped;

  complete_binary_tree_traversal_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .out_value_o (out_value_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  // Clock generation
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void push_beat(input logic [DATA_W-1:0] v, input logic lst,
                                    input logic [2:0] st);
    beat_t b;
    b.value  = v;
    b.last   = lst;
    b.status = st;
    expected_beats.push_back(b);
  endfunction

  // Walk the array-held tree with an explicit stack; return the visit count
  function automatic int walk_tree(input logic [2:0] order);
    int stk_idx[CAPACITY];
    int stk_ph[CAPACITY];
    int sp;
    int n;
    int node;
    sp = 1;
    n = 0;
    stk_idx[0] = 0;
    stk_ph[0] = 0;
    while (sp > 0) begin
      node = stk_idx[sp-1];
      if (stk_ph[sp-1] == 0) begin
        if (order == FUNC_PREORDER) begin
          visit_buf[n] = tree_vals[node];
          n++;
        end
        stk_ph[sp-1] = 1;
        if (2 * node + 1 < tree_cnt) begin
          stk_idx[sp] = 2 * node + 1;
          stk_ph[sp] = 0;
          sp++;
        end
      end else if (stk_ph[sp-1] == 1) begin
        if (order == FUNC_INORDER) begin
          visit_buf[n] = tree_vals[node];
          n++;
        end
        stk_ph[sp-1] = 2;
        if (2 * node + 2 < tree_cnt) begin
          stk_idx[sp] = 2 * node + 2;
          stk_ph[sp] = 0;
          sp++;
        end
      end else begin
        if (order == FUNC_POSTORD) begin
          visit_buf[n] = tree_vals[node];
          n++;
        end
        sp--;
      end
    end
    return n;
  endfunction

  // Predict the result beats of one accepted request
  function automatic void predict_request(input logic [2:0] fn, input logic [DATA_W-1:0] v);
    int  n;
    logic hit;
    case (fn)
      FUNC_INSERT: begin
        n_insert++;
        if (tree_cnt >= CAPACITY) begin
          n_refused++;
          push_beat('0, 1'b1, STAT_FULL);
        end else begin
          tree_vals[tree_cnt] = v;
          tree_cnt++;
          push_beat('0, 1'b1, STAT_INSERTED);
        end
      end
      FUNC_INORDER, FUNC_PREORDER, FUNC_POSTORD: begin
        n_walk++;
        if (tree_cnt == 0) begin
          push_beat('0, 1'b1, STAT_EMPTY);
        end else begin
          n = walk_tree(fn);
          for (int k = 0; k < n; k++) push_beat(visit_buf[k], k == n - 1, STAT_ELEMENT);
        end
      end
      FUNC_SEARCH: begin
        n_search++;
        hit = 1'b0;
        for (int k = 0; k < tree_cnt; k++) if (tree_vals[k] == v) hit = 1'b1;
        push_beat('0, 1'b1, hit ? STAT_FOUND : STAT_NOT_FOUND);
      end
      default: n_dropped++;
    endcase
  endfunction

  function automatic void add_req(input logic [2:0] fn, input logic [DATA_W-1:0] v);
    request_t r;
    r.func  = fn;
    r.value = v;
    pending_reqs.push_back(r);
    if (fn == FUNC_INSERT && gen_vals.size() < CAPACITY) gen_vals.push_back(v);
  endfunction

  // Mostly random words, with extremes and repeats of stored values mixed in
  function automatic logic [DATA_W-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 32'h8000_0000;
    if (sel < 10) return 32'h7FFF_FFFF;
    if (sel < 13) return 32'hFFFF_FFFF;
    if (sel < 16) return 32'h0000_0000;
    if (sel < 36 && gen_vals.size() != 0) return gen_vals[$urandom_range(0, gen_vals.size() - 1)];
    return $urandom;
  endfunction

  // Driver: offer the next request when the line is free or the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || beat_taken) begin
        if (pending_reqs.size() != 0 &&
            ((driven_cnt >= 220 && driven_cnt < 330) || $urandom_range(0, 99) >= 24)) begin
          cur_req = pending_reqs.pop_front();
          start   <= 1'b1;
          func_i  <= cur_req.func;
          value_i <= cur_req.value;
          driven_cnt++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: record accepted requests, then check each result beat in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      beat_taken = start && !busy;
      if (beat_taken) begin
        predict_request(func_i, value_i);
        accepted_cnt++;
      end
      if (strobe_o) begin
        if (expected_beats.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected beat: value %h last %b status %0d",
                     out_value_o, last_o, status_o);
        end else begin
          exp_beat = expected_beats.pop_front();
          checked_cnt++;
          if (out_value_o !== exp_beat.value || last_o !== exp_beat.last ||
              status_o !== exp_beat.status) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("beat %0d mismatch: expected %h/%b/%0d, got %h/%b/%0d", checked_cnt,
                       exp_beat.value, exp_beat.last, exp_beat.status,
                       out_value_o, last_o, status_o);
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned sel;
    int unsigned guard;
    start        = 1'b0;
    func_i       = FUNC_INSERT;
    value_i      = '0;
    rst_ni       = 1'b0;
    beat_taken   = 1'b0;
    tree_cnt     = 0;
    driven_cnt   = 0;
    accepted_cnt = 0;
    checked_cnt  = 0;
    fail_cnt     = 0;
    n_insert     = 0;
    n_refused    = 0;
    n_walk       = 0;
    n_search     = 0;
    n_dropped    = 0;

    // Empty tree: every traversal and a search, plus dropped codes
    add_req(FUNC_INORDER, 32'h1234_5678);
    add_req(FUNC_PREORDER, '0);
    add_req(FUNC_POSTORD, 32'hFFFF_FFFF);
    add_req(FUNC_SEARCH, '0);
    add_req(FUNC_RSVD5, 32'hAAAA_AAAA);
    add_req(FUNC_RSVD6, 32'h5555_5555);
    add_req(FUNC_RSVD7, 32'hFFFF_FFFF);
    // Extremes and a duplicate, then searches and traversals of the small tree
    add_req(FUNC_INSERT, 32'h8000_0000);
    add_req(FUNC_INSERT, 32'h7FFF_FFFF);
    add_req(FUNC_INSERT, 32'h0000_0000);
    add_req(FUNC_INSERT, 32'hFFFF_FFFF);
    add_req(FUNC_INSERT, 32'h0000_0000);
    add_req(FUNC_SEARCH, 32'h8000_0000);
    add_req(FUNC_SEARCH, 32'h7FFF_FFFE);
    add_req(FUNC_SEARCH, 32'hFFFF_FFFF);
    add_req(FUNC_INORDER, '0);
    add_req(FUNC_PREORDER, '0);
    add_req(FUNC_POSTORD, '0);
    add_req(FUNC_INSERT, 32'h0000_0001);
    add_req(FUNC_INORDER, '0);
    add_req(FUNC_SEARCH, 32'h0000_0001);

    // Random mix; the tree fills and later inserts are refused
    for (int k = 0; k < RANDOM_REQS; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) add_req(FUNC_INSERT, pick_word());
      else if (sel < 50) add_req(FUNC_INORDER, $urandom);
      else if (sel < 60) add_req(FUNC_PREORDER, $urandom);
      else if (sel < 70) add_req(FUNC_POSTORD, $urandom);
      else if (sel < 95) add_req(FUNC_SEARCH, pick_word());
      else add_req(3'($urandom_range(5, 7)), $urandom);
    end
    total_reqs = pending_reqs.size();

    // Hold reset, release away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (accepted_cnt == total_reqs);
    guard = 0;
    while (expected_beats.size() != 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      fail_cnt++;
      $display("%0d expected beats never arrived", expected_beats.size());
    end

    $display("Ran %0d requests: %0d inserts (%0d refused), %0d traversals, %0d searches",
             accepted_cnt, n_insert, n_refused, n_walk, n_search);
    $display("%0d dropped codes; %0d result beats checked, tree ended at %0d nodes",
             n_dropped, checked_cnt, tree_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 800000);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cbt_pkg.sv
hw/rtl/cbt_ram.sv
hw/rtl/cbt_dp.sv
hw/rtl/cbt_ctrl.sv
hw/rtl/complete_binary_tree_traversal_unit.sv
tb/complete_binary_tree_traversal_unit_tb.sv
